>>> src/pmu_pkg.sv
// Package for the particle motion update core.
// Holds the payload structs, pipeline depth constants and the saturation helper.
package pmu_pkg;

   localparam int ALPHA_BITS = 17;
   localparam int DIV_STAGES = 17;
   localparam int PIPE_DEPTH = DIV_STAGES + 1;
   localparam int MOTION_STAGES = 4;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [31:0] life_span;
      logic [31:0] age;
      logic [ALPHA_BITS-1:0] alpha_in;
      logic [15:0] dt;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic [31:0] new_age;
      logic [ALPHA_BITS-1:0] alpha_out;
      logic dead;
   } rsp_type;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) r = 32'sh7FFFFFFF;
      else if (v < SAT_MIN) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

>>> src/pmu_motion.sv
// Velocity and position pipeline of the particle motion update core.
// Depends on pmu_pkg; four compute stages padded to the full pipeline depth.
module pmu_motion #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic en,
   input  logic signed [31:0] gravity,
   input  logic [30:0] resistance,
   input  logic signed [31:0] pos_x,
   input  logic signed [31:0] pos_y,
   input  logic signed [31:0] vel_x,
   input  logic signed [31:0] vel_y,
   input  logic [15:0] dt,
   output logic signed [31:0] new_pos_x,
   output logic signed [31:0] new_pos_y,
   output logic signed [31:0] new_vel_x,
   output logic signed [31:0] new_vel_y
);
   localparam int PAD = pmu_pkg::PIPE_DEPTH - pmu_pkg::MOTION_STAGES;

   logic signed [63:0] s1_pdrag_ff, s1_pdrag_in, s1_pgrav_ff, s1_pgrav_in;
   logic signed [31:0] s1_px_ff, s1_py_ff, s1_vx_ff, s1_vy_ff;
   logic [15:0] s1_dt_ff, s2_dt_ff;
   logic signed [31:0] s2_px_ff, s2_py_ff, s2_vx_ff, s2_vx_in, s2_vy_ff, s2_vy_in;
   logic signed [63:0] s3_pvx_ff, s3_pvx_in, s3_pvy_ff, s3_pvy_in;
   logic signed [31:0] s3_px_ff, s3_py_ff, s3_vx_ff, s3_vy_ff;
   logic signed [31:0] s4_px_ff, s4_px_in, s4_py_ff, s4_py_in, s4_vx_ff, s4_vy_ff;
   logic signed [31:0] pad_px_ff [0:PAD-1];
   logic signed [31:0] pad_py_ff [0:PAD-1];
   logic signed [31:0] pad_vx_ff [0:PAD-1];
   logic signed [31:0] pad_vy_ff [0:PAD-1];
   logic signed [63:0] drag, vx_wide, grav_step, vx_move, vy_move;

   always_comb begin
      s1_pdrag_in = 64'($signed({1'b0, resistance})) * 64'($signed({1'b0, dt}));
      s1_pgrav_in = 64'(gravity) * 64'($signed({1'b0, dt}));
   end

   always_comb begin
      drag = s1_pdrag_ff >>> FRAC_BITS;
      grav_step = s1_pgrav_ff >>> FRAC_BITS;
      vx_wide = 64'(s1_vx_ff);
      if (s1_vx_ff > 0) begin
         vx_wide = 64'(s1_vx_ff) - drag;
         if (vx_wide < 0) vx_wide = '0;
      end else if (s1_vx_ff < 0) begin
         vx_wide = 64'(s1_vx_ff) + drag;
         if (vx_wide > 0) vx_wide = '0;
      end
      s2_vx_in = vx_wide[31:0];
      s2_vy_in = pmu_pkg::sat32(64'(s1_vy_ff) + grav_step);
   end

   always_comb begin
      s3_pvx_in = 64'(s2_vx_ff) * 64'($signed({1'b0, s2_dt_ff}));
      s3_pvy_in = 64'(s2_vy_ff) * 64'($signed({1'b0, s2_dt_ff}));
   end

   always_comb begin
      vx_move = s3_pvx_ff >>> FRAC_BITS;
      vy_move = s3_pvy_ff >>> FRAC_BITS;
      s4_px_in = pmu_pkg::sat32(64'(s3_px_ff) + vx_move);
      s4_py_in = pmu_pkg::sat32(64'(s3_py_ff) + vy_move);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pdrag_ff <= s1_pdrag_in;
         s1_pgrav_ff <= s1_pgrav_in;
         s1_px_ff <= pos_x;
         s1_py_ff <= pos_y;
         s1_vx_ff <= vel_x;
         s1_vy_ff <= vel_y;
         s1_dt_ff <= dt;
         s2_px_ff <= s1_px_ff;
         s2_py_ff <= s1_py_ff;
         s2_vx_ff <= s2_vx_in;
         s2_vy_ff <= s2_vy_in;
         s2_dt_ff <= s1_dt_ff;
         s3_pvx_ff <= s3_pvx_in;
         s3_pvy_ff <= s3_pvy_in;
         s3_px_ff <= s2_px_ff;
         s3_py_ff <= s2_py_ff;
         s3_vx_ff <= s2_vx_ff;
         s3_vy_ff <= s2_vy_ff;
         s4_px_ff <= s4_px_in;
         s4_py_ff <= s4_py_in;
         s4_vx_ff <= s3_vx_ff;
         s4_vy_ff <= s3_vy_ff;
         pad_px_ff[0] <= s4_px_ff;
         pad_py_ff[0] <= s4_py_ff;
         pad_vx_ff[0] <= s4_vx_ff;
         pad_vy_ff[0] <= s4_vy_ff;
         for (int i = 1; i < PAD; i++) begin
            pad_px_ff[i] <= pad_px_ff[i-1];
            pad_py_ff[i] <= pad_py_ff[i-1];
            pad_vx_ff[i] <= pad_vx_ff[i-1];
            pad_vy_ff[i] <= pad_vy_ff[i-1];
         end
      end
   end

   assign new_pos_x = pad_px_ff[PAD-1];
   assign new_pos_y = pad_py_ff[PAD-1];
   assign new_vel_x = pad_vx_ff[PAD-1];
   assign new_vel_y = pad_vy_ff[PAD-1];
endmodule

>>> src/pmu_alpha.sv
// Opacity, age and expiry pipeline of the particle motion update core.
// Depends on pmu_pkg; a restoring divider that resolves one quotient bit per stage.
module pmu_alpha (
   input  logic clock,
   input  logic en,
   input  logic [31:0] life_span,
   input  logic [31:0] age,
   input  logic [pmu_pkg::ALPHA_BITS-1:0] alpha_in,
   input  logic [15:0] dt,
   output logic [31:0] new_age,
   output logic [pmu_pkg::ALPHA_BITS-1:0] alpha_out,
   output logic dead
);
   localparam int N = pmu_pkg::DIV_STAGES;
   localparam int AB = pmu_pkg::ALPHA_BITS;
   localparam logic [AB-1:0] ALPHA_ONE = AB'(65536);

   logic [32:0] rem_ff [0:N];
   logic [31:0] div_ff [0:N];
   logic [AB-1:0] quo_ff [0:N];
   logic [AB-1:0] fix_ff [0:N];
   logic use_fix_ff [0:N];
   logic [31:0] age_ff [0:N];
   logic dead_ff [0:N];
   logic [32:0] age_sum;
   logic [AB-1:0] fix_in;
   logic expired;

   always_comb begin
      expired = age >= life_span;
      age_sum = {1'b0, age} + 33'(dt);
      if (life_span == '0) fix_in = (alpha_in > ALPHA_ONE) ? ALPHA_ONE : alpha_in;
      else fix_in = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {1'b0, life_span - age};
         div_ff[0] <= life_span;
         quo_ff[0] <= '0;
         fix_ff[0] <= fix_in;
         use_fix_ff[0] <= expired;
         dead_ff[0] <= expired;
         if (expired) age_ff[0] <= age;
         else age_ff[0] <= age_sum[32] ? 32'hFFFFFFFF : age_sum[31:0];
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_div
      logic [32:0] r_sh, r_sub;
      logic take;
      always_comb begin
         r_sh = (k == 0) ? rem_ff[k] : {rem_ff[k][31:0], 1'b0};
         take = r_sh >= {1'b0, div_ff[k]};
         r_sub = take ? r_sh - {1'b0, div_ff[k]} : r_sh;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= r_sub;
            div_ff[k+1] <= div_ff[k];
            quo_ff[k+1] <= {quo_ff[k][AB-2:0], take};
            fix_ff[k+1] <= fix_ff[k];
            use_fix_ff[k+1] <= use_fix_ff[k];
            age_ff[k+1] <= age_ff[k];
            dead_ff[k+1] <= dead_ff[k];
         end
      end
   end

   assign new_age = age_ff[N];
   assign dead = dead_ff[N];
   assign alpha_out = use_fix_ff[N] ? fix_ff[N] : quo_ff[N];
endmodule

>>> src/particle_motion_update_core.sv
// Particle motion update core: one semi-implicit Euler step per particle.
// The pipeline depth is set by the 17-stage opacity divider plus its input stage.
// Throughput is one particle per cycle; a stalled output freezes the whole pipeline.
// Synchronous reset clears the valid chain and sets gravity and resistance to zero.
module particle_motion_update_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  pmu_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output pmu_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [31:0] csr_wdata
);
   localparam logic CSR_GRAVITY = 1'b0;
   localparam logic CSR_RESISTANCE = 1'b1;
   localparam int D = pmu_pkg::PIPE_DEPTH;

   logic signed [31:0] gravity_ff;
   logic [30:0] resistance_ff;
   logic [D-1:0] vld_ff, vld_in;
   logic en;

   assign en = !vld_ff[D-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[D-1];
   assign vld_in = {vld_ff[D-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         gravity_ff <= '0;
         resistance_ff <= '0;
      end else begin
         if (en) vld_ff <= vld_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_GRAVITY: gravity_ff <= csr_wdata;
               CSR_RESISTANCE: resistance_ff <= csr_wdata[30:0];
               default: ;
            endcase
         end
      end
   end

   pmu_motion #(.FRAC_BITS(FRAC_BITS)) u_motion (
      .clock(clock),
      .en(en),
      .gravity(gravity_ff),
      .resistance(resistance_ff),
      .pos_x(req_data.pos_x),
      .pos_y(req_data.pos_y),
      .vel_x(req_data.vel_x),
      .vel_y(req_data.vel_y),
      .dt(req_data.dt),
      .new_pos_x(rsp_data.new_pos_x),
      .new_pos_y(rsp_data.new_pos_y),
      .new_vel_x(rsp_data.new_vel_x),
      .new_vel_y(rsp_data.new_vel_y)
   );

   pmu_alpha u_alpha (
      .clock(clock),
      .en(en),
      .life_span(req_data.life_span),
      .age(req_data.age),
      .alpha_in(req_data.alpha_in),
      .dt(req_data.dt),
      .new_age(rsp_data.new_age),
      .alpha_out(rsp_data.alpha_out),
      .dead(rsp_data.dead)
   );
endmodule

>>> tb/particle_motion_update_checker.sv
// Checker for the particle motion update core: watches both channels, predicts
// each particle update and compares it with the transfers on the result channel.
// Depends on pmu_pkg for the payload structs.
`timescale 1ns / 100ps
module particle_motion_update_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  pmu_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  pmu_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [31:0] csr_wdata,
   output int errors,
   output int pending
);
   localparam logic CSR_GRAVITY = 1'b0;
   localparam logic CSR_RESISTANCE = 1'b1;

   logic signed [63:0] gravity_q;
   logic [63:0] resistance_q;
   pmu_pkg::rsp_type expected_updates[$];

   assign pending = expected_updates.size();

   function automatic logic signed [63:0] floor_frac(input logic signed [63:0] p);
      return p >>> 16;
   endfunction

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic pmu_pkg::rsp_type predict_update(input pmu_pkg::req_type r);
      pmu_pkg::rsp_type o;
      logic signed [63:0] dt, drag, vx, vy, nx, ny;
      logic [63:0] life, age, alpha, nage;
      dt = {48'd0, r.dt};
      drag = floor_frac($signed(resistance_q) * dt);
      vx = r.vel_x;
      if (vx > 0) begin
         vx = vx - drag;
         if (vx < 0) vx = 0;
      end else if (vx < 0) begin
         vx = vx + drag;
         if (vx > 0) vx = 0;
      end
      vy = clamp32(64'(r.vel_y) + floor_frac(gravity_q * dt));
      nx = clamp32(64'(r.pos_x) + floor_frac(vx * dt));
      ny = clamp32(64'(r.pos_y) + floor_frac(vy * dt));
      life = {32'd0, r.life_span};
      age = {32'd0, r.age};
      alpha = {47'd0, r.alpha_in};
      if (life > 0) begin
         if (age >= life) alpha = 0;
         else alpha = ((life - age) << 16) / life;
      end
      if (alpha > 64'd65536) alpha = 64'd65536;
      if (age < life) begin
         nage = age + {48'd0, r.dt};
         if (nage > 64'hFFFFFFFF) nage = 64'hFFFFFFFF;
         o.dead = 1'b0;
      end else begin
         nage = age;
         o.dead = 1'b1;
      end
      o.new_pos_x = nx[31:0];
      o.new_pos_y = ny[31:0];
      o.new_vel_x = vx[31:0];
      o.new_vel_y = vy[31:0];
      o.new_age = nage[31:0];
      o.alpha_out = alpha[pmu_pkg::ALPHA_BITS-1:0];
      return o;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("Mismatch in %s: got %h, expected %h at %0t", field, got, want, $time);
      errors++;
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      pmu_pkg::rsp_type want;
      if (reset) begin
         gravity_q <= 0;
         resistance_q <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_GRAVITY) gravity_q <= $signed(csr_wdata);
            else resistance_q <= {33'd0, csr_wdata[30:0]};
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               $display("Unexpected result transfer at %0t", $time);
               errors++;
            end else begin
               want = expected_updates.pop_front();
               if (rsp_data.new_pos_x !== want.new_pos_x)
                  report_mismatch("new_pos_x", rsp_data.new_pos_x, want.new_pos_x);
               if (rsp_data.new_pos_y !== want.new_pos_y)
                  report_mismatch("new_pos_y", rsp_data.new_pos_y, want.new_pos_y);
               if (rsp_data.new_vel_x !== want.new_vel_x)
                  report_mismatch("new_vel_x", rsp_data.new_vel_x, want.new_vel_x);
               if (rsp_data.new_vel_y !== want.new_vel_y)
                  report_mismatch("new_vel_y", rsp_data.new_vel_y, want.new_vel_y);
               if (rsp_data.new_age !== want.new_age)
                  report_mismatch("new_age", rsp_data.new_age, want.new_age);
               if (rsp_data.alpha_out !== want.alpha_out)
                  report_mismatch("alpha_out", 32'(rsp_data.alpha_out), 32'(want.alpha_out));
               if (rsp_data.dead !== want.dead)
                  report_mismatch("dead", 32'(rsp_data.dead), 32'(want.dead));
            end
         end
         if (req_valid && req_ready) expected_updates.push_back(predict_update(req_data));
      end
   end
endmodule

>>> tb/particle_motion_update_core_tb.sv
// Top of the particle motion update testbench: clock, reset, stimulus and verdict.
// Depends on pmu_pkg, the core and particle_motion_update_checker.
`timescale 1ns / 100ps
module particle_motion_update_core_tb;
   localparam logic CSR_GRAVITY = 1'b0;
   localparam logic CSR_RESISTANCE = 1'b1;
   localparam int STALL_LIMIT = 5000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   pmu_pkg::req_type req_data;
   pmu_pkg::rsp_type rsp_data;
   logic csr_we, csr_index;
   logic [31:0] csr_wdata;
   int errors, pending;
   logic calm, hold_off;
   int idle_cycles;

   particle_motion_update_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   particle_motion_update_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            for (n = 0; n < 300; n++) @(posedge clock);
            hold_off <= 1'b0;
         end
         rsp_ready <= calm || ($urandom_range(99) >= 7);
         @(posedge clock);
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'(int'($urandom_range(2000)) - 1000) <<< 16;
         3: return 32'hFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic pmu_pkg::req_type random_particle();
      pmu_pkg::req_type r;
      r.pos_x = rand_word();
      r.pos_y = rand_word();
      r.vel_x = ($urandom_range(9) == 0) ? 32'd0 : rand_word();
      r.vel_y = rand_word();
      r.life_span = ($urandom_range(9) == 0) ? 32'd0 : rand_word();
      r.age = ($urandom_range(3) == 0) ? r.life_span - $urandom_range(3) : rand_word();
      r.alpha_in = ($urandom_range(3) == 0) ? 17'd65536 : 17'($urandom);
      r.dt = ($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom);
      return r;
   endfunction

   task automatic send_particle(input pmu_pkg::req_type r);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      int n;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      for (n = 0; n < pmu_pkg::PIPE_DEPTH + 4; n++) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   initial begin
      pmu_pkg::req_type r;
      logic [31:0] grav_set[6];
      logic [31:0] res_set[6];
      int i, k;
      grav_set = '{32'h0, 32'h80000000, 32'h7FFFFFFF,
                   32'hFFF63000, 32'h00020000, $urandom};
      res_set = '{32'h0, 32'h7FFFFFFF, 32'h0, 32'h00008000,
                  32'h00030000, $urandom};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_GRAVITY;
      csr_wdata <= '0;
      calm <= 1'b0;
      hold_off <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(CSR_GRAVITY, 32'hFFF63000);
      write_reg(CSR_RESISTANCE, 32'h00010000);
      csr_we <= 1'b0;
      for (i = 0; i < 20; i++) begin
         r = random_particle();
         case (i)
            0: r = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                     32'hFFFFFFFF, 32'h0, 17'd65536, 16'hFFFF};
            1: r = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                     32'h0, 32'hFFFFFFFF, 17'h1FFFF, 16'h0};
            2: begin r.vel_x = 0; r.life_span = 0; r.alpha_in = 17'h1FFFF; end
            3: begin r.vel_x = 32'h00000100; r.dt = 16'hFFFF; end
            4: begin r.vel_x = 32'hFFFFFF00; r.dt = 16'hFFFF; end
            5: begin r.age = 32'd100; r.life_span = 32'd100; end
            6: begin r.age = 32'hFFFFFFF0; r.life_span = 32'hFFFFFFFF; end
            7: begin r.age = 32'd0; r.life_span = 32'd1; r.alpha_in = 17'd0; end
            8: begin r.age = 32'd5; r.life_span = 32'd3; end
            default: ;
         endcase
         send_particle(r);
      end
      drain();

      for (k = 0; k < 6; k++) begin
         write_reg(CSR_GRAVITY, grav_set[k]);
         write_reg(CSR_RESISTANCE, res_set[k]);
         csr_we <= 1'b0;
         calm <= (k == 2);
         if (k == 3) hold_off <= 1'b1;
         for (i = 0; i < 255; i++) send_particle(random_particle());
         drain();
      end
      calm <= 1'b0;

      for (i = 0; i < 200; i++) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

>>> particle_motion_update_core.f
src/pmu_pkg.sv
src/pmu_motion.sv
src/pmu_alpha.sv
src/particle_motion_update_core.sv
tb/particle_motion_update_checker.sv
tb/particle_motion_update_core_tb.sv
